// ===== rtl/spc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types and codes for the shape pair collision test pipeline.
// ----------------------------------------------------------------------------
package spc_pkg;

	// Shape pair codes carried on the input tuser field.
	localparam logic [3:0] REQ_RECT_RECT = 4'd0;
	localparam logic [3:0] REQ_CIRC_CIRC = 4'd1;
	localparam logic [3:0] REQ_RECT_CIRC = 4'd2;
	localparam logic [3:0] REQ_CIRC_RECT = 4'd3;
	localparam logic [3:0] REQ_RECT_SEG  = 4'd4;
	localparam logic [3:0] REQ_SEG_RECT  = 4'd5;
	localparam logic [3:0] REQ_SEG_CIRC  = 4'd6;
	localparam logic [3:0] REQ_CIRC_SEG  = 4'd7;

	// Test kind after the operands have been put in canonical order.
	typedef enum logic [2:0] {
		K_NONE,
		K_RR,
		K_CC,
		K_RC,
		K_RS,
		K_CS
	} kind_t;

	// Control flags passed from the operand stages to the distance stages.
	typedef struct packed {
		kind_t kind;
		logic  dir;   // finished result of a rectangle-rectangle or rectangle-segment test
		logic  vert;  // segment is vertical
		logic  horz;  // segment is horizontal
	} spc_flags_t;

endpackage

// ===== rtl/spc_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_prep
// First two pipeline stages: operand ordering, bounds, and interval tests.
// ----------------------------------------------------------------------------
module spc_prep
	import spc_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [3:0]                   req_type,
	input  logic signed [COORD_BITS-1:0] a_x,
	input  logic signed [COORD_BITS-1:0] a_y,
	input  logic signed [COORD_BITS-1:0] a_ext1,
	input  logic signed [COORD_BITS-1:0] a_ext2,
	input  logic signed [COORD_BITS-1:0] b_x,
	input  logic signed [COORD_BITS-1:0] b_y,
	input  logic signed [COORD_BITS-1:0] b_ext1,
	input  logic signed [COORD_BITS-1:0] b_ext2,
	output spc_flags_t                   flags_s2,
	output logic signed [COORD_BITS+1:0] dx_s2,
	output logic signed [COORD_BITS+1:0] dy_s2,
	output logic [COORD_BITS:0]          r_s2
);

	localparam int N = COORD_BITS;
	localparam int W = COORD_BITS + 1;
	localparam int D = COORD_BITS + 2;

	// Stage 1 combinational: pick the primary shape and build bounds.
	kind_t               kind_d;
	logic                swap;
	logic signed [N-1:0] px, py, pe1, pe2, qx, qy, qe1, qe2;
	logic [N-1:0]        pw, ph, qw, qh;
	logic [W-1:0]        r_d;

	always_comb begin
		kind_d = K_NONE;
		swap   = 1'b0;
		case (req_type)
			REQ_RECT_RECT: kind_d = K_RR;
			REQ_CIRC_CIRC: kind_d = K_CC;
			REQ_RECT_CIRC: kind_d = K_RC;
			REQ_CIRC_RECT: begin
				kind_d = K_RC;
				swap   = 1'b1;
			end
			REQ_RECT_SEG:  kind_d = K_RS;
			REQ_SEG_RECT: begin
				kind_d = K_RS;
				swap   = 1'b1;
			end
			REQ_SEG_CIRC: begin
				kind_d = K_CS;
				swap   = 1'b1;
			end
			REQ_CIRC_SEG:  kind_d = K_CS;
			default:       kind_d = K_NONE;
		endcase
	end

	assign px  = swap ? b_x    : a_x;
	assign py  = swap ? b_y    : a_y;
	assign pe1 = swap ? b_ext1 : a_ext1;
	assign pe2 = swap ? b_ext2 : a_ext2;
	assign qx  = swap ? a_x    : b_x;
	assign qy  = swap ? a_y    : b_y;
	assign qe1 = swap ? a_ext1 : b_ext1;
	assign qe2 = swap ? a_ext2 : b_ext2;

	// Negative sizes count as zero.
	assign pw = pe1[N-1] ? '0 : pe1;
	assign ph = pe2[N-1] ? '0 : pe2;
	assign qw = qe1[N-1] ? '0 : qe1;
	assign qh = qe2[N-1] ? '0 : qe2;

	always_comb begin
		case (kind_d)
			K_CC:    r_d = W'(pw) + W'(qw);
			K_RC:    r_d = W'(qw);
			default: r_d = W'(pw);
		endcase
	end

	kind_t               kind_s1;
	logic signed [N-1:0] px_s1, py_s1, qx_s1, qy_s1, qe1_s1, qe2_s1;
	logic signed [W-1:0] px1_s1, py1_s1, qx1_s1, qy1_s1;
	logic [W-1:0]        r_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= kind_d;
			px_s1   <= px;
			py_s1   <= py;
			qx_s1   <= qx;
			qy_s1   <= qy;
			qe1_s1  <= qe1;
			qe2_s1  <= qe2;
			px1_s1  <= W'(px) + $signed(W'(pw));
			py1_s1  <= W'(py) + $signed(W'(ph));
			qx1_s1  <= W'(qx) + $signed(W'(qw));
			qy1_s1  <= W'(qy) + $signed(W'(qh));
			r_s1    <= r_d;
		end
	end

	// Stage 2 combinational: interval tests, clamp and centre differences.
	logic                vert, horz, rr_hit, rs_hit, dir_d;
	logic signed [N-1:0] qlo_x, qhi_x, qlo_y, qhi_y;
	logic signed [W-1:0] cx_clamp, cy_clamp;
	logic signed [D-1:0] dx_d, dy_d;

	assign vert  = (qx_s1 == qe1_s1);
	assign horz  = (qy_s1 == qe2_s1);
	assign qlo_x = (qx_s1 < qe1_s1) ? qx_s1 : qe1_s1;
	assign qhi_x = (qx_s1 < qe1_s1) ? qe1_s1 : qx_s1;
	assign qlo_y = (qy_s1 < qe2_s1) ? qy_s1 : qe2_s1;
	assign qhi_y = (qy_s1 < qe2_s1) ? qe2_s1 : qy_s1;

	assign rr_hit = (px_s1 <= qx1_s1) && (qx_s1 <= px1_s1) &&
	                (py_s1 <= qy1_s1) && (qy_s1 <= py1_s1);

	assign rs_hit = (vert && (qx_s1 >= px_s1) && (qx_s1 <= px1_s1) &&
	                 (qlo_y <= py1_s1) && (py_s1 <= qhi_y)) ||
	                (horz && (qy_s1 >= py_s1) && (qy_s1 <= py1_s1) &&
	                 (qlo_x <= px1_s1) && (px_s1 <= qhi_x));

	// Nearest point of the box to the circle centre.
	assign cx_clamp = (qx_s1 < px_s1) ? W'(px_s1) : ((qx_s1 > px1_s1) ? px1_s1 : W'(qx_s1));
	assign cy_clamp = (qy_s1 < py_s1) ? W'(py_s1) : ((qy_s1 > py1_s1) ? py1_s1 : W'(qy_s1));

	always_comb begin
		if (kind_s1 == K_RC) begin
			dx_d = D'(qx_s1) - D'(cx_clamp);
			dy_d = D'(qy_s1) - D'(cy_clamp);
		end else begin
			dx_d = D'(px_s1) - D'(qx_s1);
			dy_d = D'(py_s1) - D'(qy_s1);
		end
	end

	always_comb begin
		case (kind_s1)
			K_RR:    dir_d = rr_hit;
			K_RS:    dir_d = rs_hit;
			default: dir_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s2.kind <= kind_s1;
			flags_s2.dir  <= dir_d;
			flags_s2.vert <= vert;
			flags_s2.horz <= horz;
			dx_s2         <= dx_d;
			dy_s2         <= dy_d;
			r_s2          <= r_s1;
		end
	end

endmodule

// ===== rtl/shape_pair_collision_test_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shape_pair_collision_test_top
// Five-stage pipeline that tests one pair of 2D shapes per cycle for contact while it is not stalled.
// ----------------------------------------------------------------------------
// Each transfer on the slave channel carries one pair of shapes: tuser holds
// the pair code (rectangle, circle or axis-aligned segment combinations) and
// tdata holds the eight signed coordinates. Each transfer on the master
// channel carries one hit flag, set when the shapes touch or overlap.
// Every input transfer gives exactly one output transfer, in order.
//
// The hit flag of a pair shows on m_tvalid once the pair reaches the output
// register, the last of the five register stages (operand setup, interval
// tests, absolute distances, squaring, and the final sum compare). Each stage
// holds one pair and takes a new pair in every cycle in which the pipeline
// advances, so throughput is one pair per cycle while m_tready stays high.
//
// The whole pipeline advances together whenever the output register is empty
// or being taken. When the receiver holds m_tready low with a result waiting,
// every stage freezes and s_tready drops, so nothing is lost or repeated.
// Reset clears all valid bits; the block is ready for input right after.
// ----------------------------------------------------------------------------
module shape_pair_collision_test_top
	import spc_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// Slave channel.
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// tdata fields from bit 0 up: a_x, a_y, a_ext1, a_ext2, b_x, b_y, b_ext1, b_ext2
	input  logic [8*COORD_BITS-1:0] s_tdata,
	// tuser fields from bit 0 up: req_type
	input  logic [3:0]              s_tuser,
	// Master channel.
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// tdata fields from bit 0 up: hit, then seven zero bits
	output logic [7:0]              m_tdata
);

	localparam int N = COORD_BITS;
	localparam int W = COORD_BITS + 1;
	localparam int D = COORD_BITS + 2;
	localparam int P = 2 * COORD_BITS + 2;

	// One enable moves every stage; the output register is the last stage.
	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	assign en       = !v_s5 || m_tready;
	assign s_tready = en;
	assign m_tvalid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stages 1 and 2: operand ordering, bounds and interval tests.
	spc_flags_t          flags_s2;
	logic signed [D-1:0] dx_s2, dy_s2;
	logic [W-1:0]        r_s2;

	spc_prep #(
		.COORD_BITS (COORD_BITS)
	) u_prep (
		.clk      (clk),
		.en       (en),
		.req_type (s_tuser),
		.a_x      (s_tdata[0*N +: N]),
		.a_y      (s_tdata[1*N +: N]),
		.a_ext1   (s_tdata[2*N +: N]),
		.a_ext2   (s_tdata[3*N +: N]),
		.b_x      (s_tdata[4*N +: N]),
		.b_y      (s_tdata[5*N +: N]),
		.b_ext1   (s_tdata[6*N +: N]),
		.b_ext2   (s_tdata[7*N +: N]),
		.flags_s2 (flags_s2),
		.dx_s2    (dx_s2),
		.dy_s2    (dy_s2),
		.r_s2     (r_s2)
	);

	// Stage 3: absolute distances. A distance larger than the radius on either
	// axis rules out a circle hit, which also keeps the squares narrow. The
	// circle-segment test only needs the distance to the segment's line, so it
	// finishes here.
	logic [D-1:0] adx, ady;
	logic         far, cs_hit;

	assign adx    = dx_s2[D-1] ? D'(-dx_s2) : D'(dx_s2);
	assign ady    = dy_s2[D-1] ? D'(-dy_s2) : D'(dy_s2);
	assign far    = (adx > D'(r_s2)) || (ady > D'(r_s2));
	assign cs_hit = (flags_s2.vert && (adx <= D'(r_s2))) ||
	                (flags_s2.horz && (ady <= D'(r_s2)));

	logic [W-1:0] ax_s3, ay_s3, r_s3;
	logic         dir_s3, sq_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s3  <= adx[W-1:0];
			ay_s3  <= ady[W-1:0];
			r_s3   <= r_s2;
			dir_s3 <= (flags_s2.kind == K_CS) ? cs_hit : flags_s2.dir;
			sq_s3  <= ((flags_s2.kind == K_CC) || (flags_s2.kind == K_RC)) && !far;
		end
	end

	// Stage 4: squares of both distances and of the radius.
	logic [P-1:0] x2_s4, y2_s4, r2_s4;
	logic         dir_s4, sq_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			x2_s4  <= P'(ax_s3) * P'(ax_s3);
			y2_s4  <= P'(ay_s3) * P'(ay_s3);
			r2_s4  <= P'(r_s3) * P'(r_s3);
			dir_s4 <= dir_s3;
			sq_s4  <= sq_s3;
		end
	end

	// Stage 5: squared distance against squared radius; this is the output
	// register.
	logic [P:0] dist2;
	logic       hit_s5;

	assign dist2 = (P+1)'(x2_s4) + (P+1)'(y2_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s5 <= dir_s4 || (sq_s4 && (dist2 <= (P+1)'(r2_s4)));
		end
	end

	assign m_tdata = {7'b0, hit_s5};

endmodule
